### sv/bed_pkg.sv
package bed_pkg;

  // Default sizing of the string and cell stores.
  localparam int MAX_LEN_DEF   = 4096;
  localparam int DIST_BITS_DEF = 13;

  // Fixed field widths of the channels and of the threshold register.
  localparam int ACTION_W = 2;
  localparam int SYMBOL_W = 8;
  localparam int DIST_W   = 13;
  localparam int THR_W    = 14;

  // Action codes of an input item.
  localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

  // Threshold value that selects the first string's length as the band.
  localparam logic signed [THR_W-1:0] THR_AUTO = -14'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic fail;
    logic init;
    logic bounds;
    logic row_start;
    logic row_prep;
    logic cell_step;
    logic fin_read;
    logic capture;
    logic publish;
  } bed_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early_fail;
    logic init_last;
    logic a_empty;
    logic cell_last;
    logic row_last;
  } bed_sts_t;

endpackage

### sv/bed_if.sv
// Request channel: one item loads a symbol or starts a computation.
interface bed_req_if;
  logic                          valid;
  logic                          ready;
  logic [bed_pkg::ACTION_W-1:0]  action;
  logic [bed_pkg::SYMBOL_W-1:0]  symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink (input valid, input action, input symbol, output ready);
endinterface

// Result channel: one item per computation.
interface bed_res_if;
  logic                        valid;
  logic                        ready;
  logic [bed_pkg::DIST_W-1:0]  distance;
  logic                        found;

  modport source (output valid, output distance, output found, input ready);
  modport sink (input valid, input distance, input found, output ready);
endinterface

### sv/bed_ctrl.sv
module bed_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [bed_pkg::ACTION_W-1:0]  req_action,
  output logic                          req_ready,
  input  logic                          res_ready,
  output logic                          res_valid,
  input  bed_pkg::bed_sts_t             sts,
  output bed_pkg::bed_cmd_t             cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_PREP      = 10'b00_0000_0010,
    S_INIT      = 10'b00_0000_0100,
    S_BOUNDS    = 10'b00_0000_1000,
    S_ROW_START = 10'b00_0001_0000,
    S_ROW_PREP  = 10'b00_0010_0000,
    S_CELL      = 10'b00_0100_0000,
    S_FIN_READ  = 10'b00_1000_0000,
    S_FIN_CMP   = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE);

  // Sequencing of load, initialisation, band rows and result.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_action)
            bed_pkg::ACT_LOAD_A: cmd.load_a = 1'b1;
            bed_pkg::ACT_LOAD_B: cmd.load_b = 1'b1;
            bed_pkg::ACT_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = S_PREP;
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        if (sts.early_fail) begin
          cmd.fail   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.init_last) begin
          state_next = sts.a_empty ? S_FIN_READ : S_BOUNDS;
        end
      end
      S_BOUNDS: begin
        cmd.bounds = 1'b1;
        state_next = S_ROW_START;
      end
      S_ROW_START: begin
        cmd.row_start = 1'b1;
        state_next    = S_ROW_PREP;
      end
      S_ROW_PREP: begin
        cmd.row_prep = 1'b1;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.cell_step = 1'b1;
        if (sts.cell_last) begin
          state_next = sts.row_last ? S_FIN_READ : S_BOUNDS;
        end
      end
      S_FIN_READ: begin
        cmd.fin_read = 1'b1;
        state_next   = S_FIN_CMP;
      end
      S_FIN_CMP: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/bed_datapath.sv
module bed_datapath #(
  parameter int MAX_LEN   = bed_pkg::MAX_LEN_DEF,
  parameter int DIST_BITS = bed_pkg::DIST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic signed [bed_pkg::THR_W-1:0]    cfg_data,
  input  logic [bed_pkg::SYMBOL_W-1:0]        symbol,
  input  bed_pkg::bed_cmd_t                   cmd,
  output bed_pkg::bed_sts_t                   sts,
  output logic [bed_pkg::DIST_W-1:0]          res_distance,
  output logic                                res_found
);

  localparam int LEN_BITS = $clog2(MAX_LEN + 1);
  localparam int AB       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TW       = (LEN_BITS > bed_pkg::THR_W - 1) ? LEN_BITS : bed_pkg::THR_W - 1;
  localparam int SW       = ((LEN_BITS > DIST_BITS) ? LEN_BITS : DIST_BITS) + 1;
  localparam int CW       = (TW > DIST_BITS) ? TW : DIST_BITS;

  localparam logic [DIST_BITS-1:0] CELL_MAX   = '1;
  localparam logic [SW-1:0]        CELL_MAX_W = SW'(CELL_MAX);
  localparam logic [LEN_BITS-1:0]  LEN_FULL   = LEN_BITS'(MAX_LEN);
  localparam logic [LEN_BITS-1:0]  LEN_ONE    = LEN_BITS'(1);

  // Clamp a length or index to the saturating cell range.
  function automatic logic [DIST_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return (w > CELL_MAX_W) ? CELL_MAX : DIST_BITS'(v);
  endfunction

  // Symbol stores and the two row buffers.
  logic [bed_pkg::SYMBOL_W-1:0] str_a [MAX_LEN];
  logic [bed_pkg::SYMBOL_W-1:0] str_b [MAX_LEN];
  logic [DIST_BITS-1:0]         row_a [MAX_LEN+1];
  logic [DIST_BITS-1:0]         row_b [MAX_LEN+1];

  logic signed [bed_pkg::THR_W-1:0] thr;
  logic [LEN_BITS-1:0]              len_a;
  logic [LEN_BITS-1:0]              len_b;

  logic [TW-1:0]                t_eff;
  logic                         t_pos;
  logic [DIST_BITS-1:0]         far;
  logic [LEN_BITS-1:0]          idx;
  logic [LEN_BITS-1:0]          row;
  logic [LEN_BITS-1:0]          col;
  logic [LEN_BITS-1:0]          lo;
  logic [LEN_BITS-1:0]          hi;
  logic                         par;
  logic [DIST_BITS-1:0]         diag;
  logic [DIST_BITS-1:0]         left;
  logic [bed_pkg::SYMBOL_W-1:0] sym_a;
  logic                         fin_found;
  logic [bed_pkg::DIST_W-1:0]   fin_dist;

  logic [bed_pkg::SYMBOL_W-1:0] str_a_q;
  logic [bed_pkg::SYMBOL_W-1:0] str_b_q;
  logic [DIST_BITS-1:0]         row_a_q;
  logic [DIST_BITS-1:0]         row_b_q;

  logic [DIST_BITS-1:0] up;
  logic [DIST_BITS-1:0] min_dl;
  logic [DIST_BITS-1:0] min_all;
  logic [DIST_BITS:0]   inc;
  logic [DIST_BITS-1:0] cell_val;
  logic                 hit;

  logic [LEN_BITS-1:0]  rd_col;
  logic [LEN_BITS-1:0]  sb_col;
  logic [LEN_BITS-1:0]  row_m1;
  logic [LEN_BITS-1:0]  wr_col;
  logic [DIST_BITS-1:0] wr_val;
  logic                 wr_new;
  logic                 we_a;
  logic                 we_b;
  logic [DIST_BITS-1:0] wd_a;
  logic [DIST_BITS-1:0] wd_b;

  logic [TW-1:0]        row_t;
  logic [TW:0]          hi_sum;
  logic [LEN_BITS-1:0]  lo_calc;
  logic [LEN_BITS-1:0]  hi_calc;

  // The older row is buffer A on even parity, buffer B on odd.
  assign up = par ? row_b_q : row_a_q;

  // One band cell: match takes the diagonal, otherwise the saturated minimum plus one.
  always_comb begin
    min_dl   = (diag < left) ? diag : left;
    min_all  = (min_dl < up) ? min_dl : up;
    inc      = {1'b0, min_all} + {{DIST_BITS{1'b0}}, 1'b1};
    cell_val = (sym_a == str_b_q) ? diag
             : (inc[DIST_BITS] ? CELL_MAX : inc[DIST_BITS-1:0]);
  end

  // Row bounds of the band, clipped to the second string.
  always_comb begin
    row_t   = TW'(row);
    lo_calc = (row_t > t_eff) ? LEN_BITS'(row_t - t_eff) : LEN_ONE;
    hi_sum  = (TW+1)'(row) + (TW+1)'(t_eff);
    hi_calc = (hi_sum > (TW+1)'(len_b)) ? len_b : LEN_BITS'(hi_sum);
  end

  // Result test against the threshold.
  assign hit = (CW'(up) < CW'(t_eff));

  // Status back to the controller.
  always_comb begin
    sts.early_fail = !t_pos || ((len_a != '0) && ((len_b == '0) ||
                     ((TW+1)'(len_a) > (TW+1)'(len_b) + (TW+1)'(t_eff))));
    sts.init_last  = (idx == len_b);
    sts.a_empty    = (len_a == '0);
    sts.cell_last  = (col == hi);
    sts.row_last   = (row == len_a);
  end

  // Read addresses: the older row one cell ahead, the second string one behind.
  always_comb begin
    row_m1 = row - LEN_ONE;
    rd_col = '0;
    if (cmd.row_start) begin
      rd_col = lo - LEN_ONE;
    end else if (cmd.row_prep) begin
      rd_col = lo;
    end else if (cmd.cell_step) begin
      rd_col = sts.cell_last ? col : col + LEN_ONE;
    end else if (cmd.fin_read) begin
      rd_col = len_b;
    end
    sb_col = rd_col - LEN_ONE;
  end

  // Write port selection for the row buffers.
  always_comb begin
    wr_col = col;
    wr_val = cell_val;
    wr_new = 1'b0;
    if (cmd.row_start) begin
      wr_col = '0;
      wr_val = sat_len(row);
      wr_new = 1'b1;
    end else if (cmd.row_prep) begin
      wr_col = lo - LEN_ONE;
      wr_val = far;
      wr_new = (lo != LEN_ONE);
    end else if (cmd.cell_step) begin
      wr_new = 1'b1;
    end
    if (cmd.init) begin
      wr_col = idx;
      we_a   = 1'b1;
      we_b   = 1'b1;
      wd_a   = (TW'(idx) <= t_eff) ? sat_len(idx) : far;
      wd_b   = far;
    end else begin
      we_a   = wr_new && par;
      we_b   = wr_new && !par;
      wd_a   = wr_val;
      wd_b   = wr_val;
    end
  end

  // Symbol stores: written on load items, read with a registered port.
  always_ff @(posedge clk) begin
    if (cmd.load_a && (len_a != LEN_FULL)) begin
      str_a[len_a[AB-1:0]] <= symbol;
    end
    if (cmd.load_b && (len_b != LEN_FULL)) begin
      str_b[len_b[AB-1:0]] <= symbol;
    end
    str_a_q <= str_a[row_m1[AB-1:0]];
    str_b_q <= str_b[sb_col[AB-1:0]];
  end

  // Row buffers: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (we_a) begin
      row_a[wr_col] <= wd_a;
    end
    if (we_b) begin
      row_b[wr_col] <= wd_b;
    end
    row_a_q <= row_a[rd_col];
    row_b_q <= row_b[rd_col];
  end

  // Threshold register and string lengths.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= bed_pkg::THR_AUTO;
      len_a <= '0;
      len_b <= '0;
    end else begin
      if (cfg_write) begin
        thr <= cfg_data;
      end
      if (cmd.load_a && (len_a != LEN_FULL)) begin
        len_a <= len_a + LEN_ONE;
      end
      if (cmd.load_b && (len_b != LEN_FULL)) begin
        len_b <= len_b + LEN_ONE;
      end
      if (cmd.publish) begin
        len_a <= '0;
        len_b <= '0;
      end
    end
  end

  // Walk registers, cell neighbours and result registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_eff <= (thr == bed_pkg::THR_AUTO) ? TW'(len_a) : TW'(thr[bed_pkg::THR_W-2:0]);
      t_pos <= (thr == bed_pkg::THR_AUTO) ? (len_a != '0)
             : (!thr[bed_pkg::THR_W-1] && (thr != '0));
      far   <= sat_len(len_a);
      idx   <= '0;
      row   <= LEN_ONE;
      par   <= 1'b0;
    end
    if (cmd.init) begin
      idx <= idx + LEN_ONE;
    end
    if (cmd.bounds) begin
      lo <= lo_calc;
      hi <= hi_calc;
    end
    if (cmd.row_prep) begin
      diag  <= up;
      sym_a <= str_a_q;
      left  <= (lo == LEN_ONE) ? sat_len(row) : far;
      col   <= lo;
    end
    if (cmd.cell_step) begin
      diag <= up;
      left <= cell_val;
      col  <= col + LEN_ONE;
      if (sts.cell_last) begin
        row <= row + LEN_ONE;
        par <= !par;
      end
    end
    if (cmd.fail) begin
      fin_found <= 1'b0;
      fin_dist  <= '0;
    end
    if (cmd.capture) begin
      fin_found <= hit;
      fin_dist  <= hit ? bed_pkg::DIST_W'(up) : '0;
    end
    if (cmd.publish) begin
      res_found    <= fin_found;
      res_distance <= fin_dist;
    end
  end

endmodule

### sv/banded_edit_distance_unit.sv
// Load items (append a symbol) are taken one per cycle while the controller is idle.
// A compute item initialises the row buffers one entry per cycle, then passes each band
// row through the bounds, row start and row prep states and walks its band cells one per
// cycle on the single read port of the older row.
// An empty band or a non-positive threshold skips the walk and returns found clear, distance zero.
// Synchronous reset clears the lengths, sets the threshold to -1 and idles the controller.
module banded_edit_distance_unit #(
  parameter int MAX_LEN   = bed_pkg::MAX_LEN_DEF,
  parameter int DIST_BITS = bed_pkg::DIST_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic signed [bed_pkg::THR_W-1:0]  cfg_data,
  bed_req_if.sink                           request,
  bed_res_if.source                         result
);

  bed_pkg::bed_cmd_t cmd;
  bed_pkg::bed_sts_t sts;
  logic              req_ready;
  logic              res_valid;

  // Controller: sequencing and handshakes.
  bed_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (request.valid),
    .req_action (request.action),
    .req_ready  (req_ready),
    .res_ready  (result.ready),
    .res_valid  (res_valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: stores, band walk and result registers.
  bed_datapath #(
    .MAX_LEN   (MAX_LEN),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .symbol       (request.symbol),
    .cmd          (cmd),
    .sts          (sts),
    .res_distance (result.distance),
    .res_found    (result.found)
  );

  assign request.ready = req_ready;
  assign result.valid  = res_valid;

  // A result is only published into an empty or draining output register.
  a_publish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!result.valid || result.ready))
    else $error("result published over an unread item");

  // A compute item closes the input until its result is published.
  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && (request.action == bed_pkg::ACT_COMPUTE))
      |=> !request.ready)
    else $error("input accepted while a computation runs");

  // A new result appears only after a publish command.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.publish))
    else $error("result valid raised without a publish");

  // The band walk never runs while the input is open.
  a_cell_closed: assert property (@(posedge clk) disable iff (rst)
    (cmd.cell_step || cmd.init) |-> !request.ready)
    else $error("input open during the band walk");

endmodule
